FILE: sv/degree_preserving_edge_swap_macros.svh
// Assertion macros for the edge swap engine.
`ifndef DEGREE_PRESERVING_EDGE_SWAP_MACROS_SVH
`define DEGREE_PRESERVING_EDGE_SWAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dpes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpes_pkg;

    // Default sizes
    localparam int DPES_NODES       = 64;
    localparam int DPES_EDGES       = 1024;
    localparam int DPES_WEIGHT_BITS = 16;

    // Fixed port widths
    localparam int STATUS_W = 3;
    localparam int RWEIGHT_W = 16;

    // Command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SWAP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SWAPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHARED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ    = 3'd4;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [RWEIGHT_W-1:0] read_weight;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/dpes_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-read memory: one write port, two registered read ports.
module dpes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: sv/dpes_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register: holds one result item until the sink takes it.
module dpes_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire dpes_pkg::t_result  i_result,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [dpes_pkg::STATUS_W-1:0]  o_status,
    output logic [dpes_pkg::RWEIGHT_W-1:0] o_read_weight
);

    import dpes_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    // room when empty or when the held item leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_data.status;
    assign o_read_weight = r_data.read_weight;

endmodule

`default_nettype wire

FILE: sv/degree_preserving_edge_swap.sv
`timescale 1ns / 1ps
`default_nettype none
`include "degree_preserving_edge_swap_macros.svh"

// Channel | Dir | Handshake                     | Item fields
// --------+-----+-------------------------------+----------------------------------
// in      | in  | i_in_valid / o_in_stall       | cmd, first_edge, second_edge,
//         |     |                               | src_node, dst_node, edge_weight
// out     | out | o_out_valid / i_out_stall     | status, read_weight
//
// One item at a time. A load writes both memories at once; a read and a swap
// wait on the registered memory reads, and an accepted swap also makes four writes
// through the single write port of the adjacency memory.
// After reset a clearing pass zeroes all NODES*NODES cells of the adjacency memory
// (4096 at the defaults), with o_in_stall high throughout.
// A stalled output holds its item; the next item is accepted meanwhile and
// waits at its final step until the output register frees.
module degree_preserving_edge_swap #(
    parameter int NODES       = dpes_pkg::DPES_NODES,
    parameter int EDGES       = dpes_pkg::DPES_EDGES,
    parameter int WEIGHT_BITS = dpes_pkg::DPES_WEIGHT_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [9:0]  i_first_edge,
    input  wire logic [9:0]  i_second_edge,
    input  wire logic [5:0]  i_src_node,
    input  wire logic [5:0]  i_dst_node,
    input  wire logic [15:0] i_edge_weight,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [dpes_pkg::STATUS_W-1:0]  o_status,
    output logic [dpes_pkg::RWEIGHT_W-1:0] o_read_weight
);

    import dpes_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int EW    = $clog2(EDGES);
    localparam int CELLS = NODES * NODES;
    localparam int AW    = $clog2(CELLS);
    localparam int EDW   = 2 * NW;
    localparam int CW    = (WEIGHT_BITS < RWEIGHT_W) ? WEIGHT_BITS : RWEIGHT_W;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LOAD     = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_READ_D   = 4'd4;
    localparam logic [3:0] S_SW_EDGE  = 4'd5;
    localparam logic [3:0] S_SW_CHK   = 4'd6;
    localparam logic [3:0] S_SW_FREE  = 4'd7;
    localparam logic [3:0] S_SW_MOVE1 = 4'd8;
    localparam logic [3:0] S_SW_MOVE2 = 4'd9;
    localparam logic [3:0] S_SW_ZERO1 = 4'd10;
    localparam logic [3:0] S_SW_ZERO2 = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    // reduce a narrow value modulo a constant by conditional subtraction
    function automatic logic [9:0] f_mod_narrow(input logic [9:0] v, input int unsigned m);
        logic [9:0]  r;
        logic [63:0] step;
        r = v;
        for (int k = 9; k >= 0; k--) begin
            step = 64'(m) << k;
            if (step < 64'd1024 && 64'(r) >= step) begin
                r = r - step[9:0];
            end
        end
        return r;
    endfunction

    // adjacency address of edge s->d
    function automatic logic [AW-1:0] f_cell(input logic [NW-1:0] s, input logic [NW-1:0] d);
        return AW'(s) * AW'(NODES) + AW'(d);
    endfunction

    // control registers
    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;

    // item registers
    logic [EW-1:0]          r_e1, n_e1, r_e2, n_e2;
    logic [NW-1:0]          r_s, n_s, r_d, n_d;
    logic [NW-1:0]          r_a, n_a, r_b, n_b, r_c, n_c, r_dd, n_dd;
    logic [WEIGHT_BITS-1:0] r_w, n_w, r_wcd, n_wcd;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [RWEIGHT_W-1:0]   r_rweight, n_rweight;

    // memory ports
    logic                   adj_we;
    logic [AW-1:0]          adj_waddr, adj_raddr_a, adj_raddr_b;
    logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata_a, adj_rdata_b;
    logic                   edg_we;
    logic [EW-1:0]          edg_waddr, edg_raddr_a, edg_raddr_b;
    logic [EDW-1:0]         edg_wdata, edg_rdata_a, edg_rdata_b;

    // output stage
    logic    out_load;
    logic    out_free;
    t_result out_result;

    // endpoints of the two swap edges as read from the edge list
    logic [NW-1:0] ed_a, ed_b, ed_c, ed_dd;
    logic          shared;

    assign ed_a  = edg_rdata_a[EDW-1:NW];
    assign ed_b  = edg_rdata_a[NW-1:0];
    assign ed_c  = edg_rdata_b[EDW-1:NW];
    assign ed_dd = edg_rdata_b[NW-1:0];
    assign shared = (r_e1 == r_e2) || (ed_a == ed_c) || (ed_a == ed_dd) ||
                    (ed_b == ed_c) || (ed_b == ed_dd);

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_e1      = r_e1;
        n_e2      = r_e2;
        n_s       = r_s;
        n_d       = r_d;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_dd      = r_dd;
        n_w       = r_w;
        n_wcd     = r_wcd;
        n_status  = r_status;
        n_rweight = r_rweight;

        adj_we      = 1'b0;
        adj_waddr   = f_cell(r_a, r_dd);
        adj_wdata   = '0;
        adj_raddr_a = f_cell(r_a, r_dd);
        adj_raddr_b = f_cell(r_c, r_b);
        edg_we      = 1'b0;
        edg_waddr   = r_e1;
        edg_wdata   = {r_a, r_dd};
        edg_raddr_a = r_e1;
        edg_raddr_b = r_e2;
        out_load    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_e1      = EW'(f_mod_narrow(i_first_edge, EDGES));
                    n_e2      = EW'(f_mod_narrow(i_second_edge, EDGES));
                    n_s       = NW'(f_mod_narrow({4'd0, i_src_node}, NODES));
                    n_d       = NW'(f_mod_narrow({4'd0, i_dst_node}, NODES));
                    n_w       = WEIGHT_BITS'(i_edge_weight[CW-1:0]);
                    n_rweight = '0;
                    case (i_cmd)
                        CMD_LOAD: n_state = S_LOAD;
                        CMD_SWAP: n_state = S_SW_EDGE;
                        default:  n_state = S_READ;
                    endcase
                end
            end
            S_LOAD: begin
                adj_we    = 1'b1;
                adj_waddr = f_cell(r_s, r_d);
                adj_wdata = r_w;
                edg_we    = 1'b1;
                edg_waddr = r_e1;
                edg_wdata = {r_s, r_d};
                n_status  = ST_LOADED;
                n_state   = S_DONE;
            end
            S_READ: begin
                adj_raddr_a = f_cell(r_s, r_d);
                n_state     = S_READ_D;
            end
            S_READ_D: begin
                n_rweight = RWEIGHT_W'(adj_rdata_a[CW-1:0]);
                n_status  = ST_READ;
                n_state   = S_DONE;
            end
            S_SW_EDGE: begin
                // edge list reads at r_e1 and r_e2 by default
                n_state = S_SW_CHK;
            end
            S_SW_CHK: begin
                n_a  = ed_a;
                n_b  = ed_b;
                n_c  = ed_c;
                n_dd = ed_dd;
                // probe the two target cells a->d and c->b
                adj_raddr_a = f_cell(ed_a, ed_dd);
                adj_raddr_b = f_cell(ed_c, ed_b);
                if (shared) begin
                    n_status = ST_SHARED;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SW_FREE;
                end
            end
            S_SW_FREE: begin
                if (adj_rdata_a != '0 || adj_rdata_b != '0) begin
                    n_status = ST_EXISTS;
                    n_state  = S_DONE;
                end else begin
                    // fetch the weights to be moved
                    adj_raddr_a = f_cell(r_a, r_b);
                    adj_raddr_b = f_cell(r_c, r_dd);
                    n_state     = S_SW_MOVE1;
                end
            end
            S_SW_MOVE1: begin
                adj_we    = 1'b1;
                adj_waddr = f_cell(r_a, r_dd);
                adj_wdata = adj_rdata_a;
                n_wcd     = adj_rdata_b;
                edg_we    = 1'b1;
                edg_waddr = r_e1;
                edg_wdata = {r_a, r_dd};
                n_state   = S_SW_MOVE2;
            end
            S_SW_MOVE2: begin
                adj_we    = 1'b1;
                adj_waddr = f_cell(r_c, r_b);
                adj_wdata = r_wcd;
                edg_we    = 1'b1;
                edg_waddr = r_e2;
                edg_wdata = {r_c, r_b};
                n_state   = S_SW_ZERO1;
            end
            S_SW_ZERO1: begin
                adj_we    = 1'b1;
                adj_waddr = f_cell(r_a, r_b);
                n_state   = S_SW_ZERO2;
            end
            S_SW_ZERO2: begin
                adj_we    = 1'b1;
                adj_waddr = f_cell(r_c, r_dd);
                n_status  = ST_SWAPPED;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        r_e1      <= n_e1;
        r_e2      <= n_e2;
        r_s       <= n_s;
        r_d       <= n_d;
        r_a       <= n_a;
        r_b       <= n_b;
        r_c       <= n_c;
        r_dd      <= n_dd;
        r_w       <= n_w;
        r_wcd     <= n_wcd;
        r_status  <= n_status;
        r_rweight <= n_rweight;
    end

    // adjacency weights
    dpes_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (CELLS)
    ) u_adj_ram (
        .i_clk     (i_clk),
        .i_we      (adj_we),
        .i_waddr   (adj_waddr),
        .i_wdata   (adj_wdata),
        .i_raddr_a (adj_raddr_a),
        .i_raddr_b (adj_raddr_b),
        .o_rdata_a (adj_rdata_a),
        .o_rdata_b (adj_rdata_b)
    );

    // edge list, {source, destination}
    dpes_ram #(
        .WIDTH (EDW),
        .DEPTH (EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_we      (edg_we),
        .i_waddr   (edg_waddr),
        .i_wdata   (edg_wdata),
        .i_raddr_a (edg_raddr_a),
        .i_raddr_b (edg_raddr_b),
        .o_rdata_a (edg_rdata_a),
        .o_rdata_b (edg_rdata_b)
    );

    assign out_result.status      = r_status;
    assign out_result.read_weight = r_rweight;

    dpes_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_result      (out_result),
        .o_free        (out_free),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_status      (o_status),
        .o_read_weight (o_read_weight)
    );

    // checks
    `DPES_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, r_state != S_IDLE, "not started")
    `DPES_ASSERT_SAME(a_no_overwrite, out_load, !o_out_valid || !i_out_stall, "result lost")
    `DPES_ASSERT_SAME(a_no_write_in_idle, r_state == S_IDLE, !adj_we && !edg_we, "idle write")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dpes_pkg::*;

    // Read command alias: code three behaves as a read
    localparam logic [1:0] CMD_READ_ALT = 2'd3;

    localparam int RANDOM_ITEMS = 1560;
    localparam int HOLD_ITEMS   = 60;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_EVERY  = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_REPORTS  = 10;

    // Block ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_cmd         = '0;
    logic [9:0]           i_first_edge  = '0;
    logic [9:0]           i_second_edge = '0;
    logic [5:0]           i_src_node    = '0;
    logic [5:0]           i_dst_node    = '0;
    logic [15:0]          i_edge_weight = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [RWEIGHT_W-1:0] o_read_weight;

    // Predicted graph state
    logic [15:0] adj_weight [0:4095];
    logic [5:0]  edge_src [0:1023];
    logic [5:0]  edge_dst [0:1023];
    bit          entry_loaded [0:1023];
    int          loaded_list [$];

    // Outcomes waiting for the block
    t_result pending_outcomes [$];
    t_result head_result;

    // Sender and receiver pacing
    int burst_left;
    bit no_gaps;
    int hold_asked;
    int hold_done;
    int hold_left;
    int stall_mode;
    int stall_phase;

    // Bookkeeping
    int cycle_count;
    int mismatches;
    int items_sent;
    int results_checked;
    int n_loads;
    int n_swapped;
    int n_shared;
    int n_exists;
    int n_reads;

    degree_preserving_edge_swap dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_first_edge  (i_first_edge),
        .i_second_edge (i_second_edge),
        .i_src_node    (i_src_node),
        .i_dst_node    (i_dst_node),
        .i_edge_weight (i_edge_weight),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_weight (o_read_weight)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: timed out after %0d cycles, %0d outcomes outstanding",
                     cycle_count, pending_outcomes.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Apply one accepted item to the graph and work out its outcome
    function automatic t_result apply_item(logic [1:0] cmd, logic [9:0] e1, logic [9:0] e2,
                                           logic [5:0] s, logic [5:0] d, logic [15:0] w);
        t_result    r;
        logic [5:0] a, b, c, dd;
        r.status      = ST_READ;
        r.read_weight = '0;
        if (cmd == CMD_LOAD) begin
            edge_src[e1] = s;
            edge_dst[e1] = d;
            adj_weight[{s, d}] = w;
            if (!entry_loaded[e1]) begin
                entry_loaded[e1] = 1'b1;
                loaded_list.push_back(int'(e1));
            end
            r.status = ST_LOADED;
            n_loads++;
        end else if (cmd == CMD_SWAP) begin
            a  = edge_src[e1];
            b  = edge_dst[e1];
            c  = edge_src[e2];
            dd = edge_dst[e2];
            if (e1 == e2 || a == c || a == dd || b == c || b == dd) begin
                r.status = ST_SHARED;
                n_shared++;
            end else if (adj_weight[{a, dd}] != '0 || adj_weight[{c, b}] != '0) begin
                r.status = ST_EXISTS;
                n_exists++;
            end else begin
                adj_weight[{a, dd}] = adj_weight[{a, b}];
                adj_weight[{a, b}]  = '0;
                adj_weight[{c, b}]  = adj_weight[{c, dd}];
                adj_weight[{c, dd}] = '0;
                edge_dst[e1] = dd;
                edge_dst[e2] = b;
                r.status = ST_SWAPPED;
                n_swapped++;
            end
        end else begin
            r.read_weight = adj_weight[{s, d}];
            n_reads++;
        end
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then pace the burst
    task automatic send_item(logic [1:0] cmd, logic [9:0] e1, logic [9:0] e2,
                             logic [5:0] s, logic [5:0] d, logic [15:0] w);
        int gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_first_edge  <= e1;
        i_second_edge <= e2;
        i_src_node    <= s;
        i_dst_node    <= d;
        i_edge_weight <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outcomes.push_back(apply_item(cmd, e1, e2, s, d, w));
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!no_gaps && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 10);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering and wait for every outstanding outcome
    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // One random item; swaps and most reads name edges already in the list
    task automatic send_random_item();
        int         pick, k1, k2;
        logic [1:0] cmd;
        logic [9:0] e1, e2;
        logic [5:0] s, d;
        logic [15:0] w;
        pick = $urandom_range(0, 99);
        e1 = 10'($urandom_range(0, 1023));
        e2 = 10'($urandom_range(0, 1023));
        s  = 6'($urandom_range(0, 63));
        d  = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 31))
            0: w = '0;
            1: w = 16'hFFFF;
            2: w = 16'h0001;
            default: w = 16'($urandom_range(1, 65535));
        endcase
        if (loaded_list.size() < 40 || pick < 22) begin
            cmd = CMD_LOAD;
            if ($urandom_range(0, 31) == 0) d = s;
        end else if (pick < 72) begin
            cmd = CMD_SWAP;
            k1 = $urandom_range(0, loaded_list.size() - 1);
            if ($urandom_range(0, 11) == 0) k2 = k1;
            else k2 = $urandom_range(0, loaded_list.size() - 1);
            e1 = 10'(loaded_list[k1]);
            e2 = 10'(loaded_list[k2]);
        end else begin
            cmd = ($urandom_range(0, 3) == 0) ? CMD_READ_ALT : CMD_READ;
            if ($urandom_range(0, 9) < 7) begin
                k1 = $urandom_range(0, loaded_list.size() - 1);
                s  = edge_src[loaded_list[k1]];
                d  = edge_dst[loaded_list[k1]];
            end
        end
        send_item(cmd, e1, e2, s, d, w);
    endtask

    // Edge loads at the field extremes, a zero weight and a self loop
    task automatic test_load_extremes();
        send_item(CMD_LOAD, 10'd0,    10'h3FF, 6'd0,  6'd63, 16'hFFFF);
        send_item(CMD_LOAD, 10'd1023, 10'h000, 6'd62, 6'd1,  16'h0001);
        send_item(CMD_LOAD, 10'd1,    10'h2AA, 6'd1,  6'd2,  16'h0000);
        send_item(CMD_LOAD, 10'd2,    10'h155, 6'd5,  6'd5,  16'h1234);
        send_item(CMD_LOAD, 10'd3,    10'h000, 6'd10, 6'd11, 16'h0100);
        send_item(CMD_LOAD, 10'd4,    10'h000, 6'd12, 6'd13, 16'h0200);
        send_item(CMD_LOAD, 10'd5,    10'h000, 6'd10, 6'd13, 16'h0007);
        send_item(CMD_LOAD, 10'd6,    10'h000, 6'd20, 6'd21, 16'h5555);
        send_item(CMD_LOAD, 10'd7,    10'h000, 6'd22, 6'd23, 16'hAAAA);
        wait_all_results();
    endtask

    // Same edge, shared vertex, taken target, accepted swaps, reload
    task automatic test_swap_cases();
        send_item(CMD_SWAP, 10'd3, 10'd3,    6'd0, 6'd0, 16'h0000);
        send_item(CMD_SWAP, 10'd3, 10'd5,    6'd0, 6'd0, 16'h0000);
        send_item(CMD_SWAP, 10'd3, 10'd4,    6'd0, 6'd0, 16'h0000);
        send_item(CMD_SWAP, 10'd0, 10'd1023, 6'd0, 6'd0, 16'h0000);
        // self loop against a disjoint edge
        send_item(CMD_SWAP, 10'd2, 10'd6,    6'd0, 6'd0, 16'h0000);
        send_item(CMD_SWAP, 10'd6, 10'd7,    6'd0, 6'd0, 16'h0000);
        // zero-weight edge takes part in a swap
        send_item(CMD_SWAP, 10'd1, 10'd4,    6'd0, 6'd0, 16'h0000);
        // reload leaves the old weight behind
        send_item(CMD_LOAD, 10'd3, 10'd0,    6'd30, 6'd31, 16'h0009);
        wait_all_results();
    endtask

    // Read back moved, cleared and stale weights, both read codes
    task automatic test_read_back();
        send_item(CMD_READ,     10'd0, 10'd0, 6'd10, 6'd11, 16'h0000);
        send_item(CMD_READ,     10'd0, 10'd0, 6'd0,  6'd1,  16'h0000);
        send_item(CMD_READ,     10'd0, 10'd0, 6'd0,  6'd63, 16'h0000);
        send_item(CMD_READ_ALT, 10'd0, 10'd0, 6'd1,  6'd2,  16'h0000);
        send_item(CMD_READ_ALT, 10'h3FF, 10'h3FF, 6'd63, 6'd63, 16'hFFFF);
        send_item(CMD_READ,     10'd0, 10'd0, 6'd5,  6'd21, 16'h0000);
        send_item(CMD_READ,     10'd0, 10'd0, 6'd12, 6'd2,  16'h0000);
        wait_all_results();
    endtask

    // Random traffic, pausing now and then until the block has drained
    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_random_item();
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) wait_all_results();
        end
        wait_all_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_hold();
        no_gaps = 1'b1;
        hold_asked++;
        for (int i = 0; i < HOLD_ITEMS; i++) send_random_item();
        no_gaps = 1'b0;
        wait_all_results();
    endtask

    // Receiver stall pattern; the long hold is counted here
    always @(negedge i_clk) begin
        stall_phase++;
        if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 6);
                default: i_out_stall <= ((stall_phase % 5) < 2);
            endcase
        end
    end

    // Compare each result item with the oldest outcome
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb_top: unexpected result status %0d weight %h",
                             o_status, o_read_weight);
            end else begin
                head_result = pending_outcomes.pop_front();
                if (o_status !== head_result.status ||
                    o_read_weight !== head_result.read_weight) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb_top: result %0d: status exp %0d got %0d, weight exp %h got %h",
                                 results_checked, head_result.status, o_status,
                                 head_result.read_weight, o_read_weight);
                end
            end
        end
    end

    initial begin
        foreach (adj_weight[k]) adj_weight[k] = '0;
        foreach (edge_src[k]) begin
            edge_src[k] = '0;
            edge_dst[k] = '0;
            entry_loaded[k] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_load_extremes();
        test_swap_cases();
        test_read_back();
        test_random_traffic();
        test_output_hold();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d items, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display("tb_top: %0d loads, %0d swaps done, %0d shared-vertex, %0d target-taken, %0d reads",
                 n_loads, n_swapped, n_shared, n_exists, n_reads);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/dpes_pkg.sv
sv/dpes_ram.sv
sv/dpes_out_stage.sv
sv/degree_preserving_edge_swap.sv
tb/sv/tb_top.sv
